[src/fixed_point_execute_unit_assert.svh]
// ----------------------------------------------------------------------------
// fixed point execute unit assertion macros
// shared helpers for concurrent checks, clocked on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_EXECUTE_UNIT_ASSERT_SVH
`define FIXED_POINT_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define FPEU_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define FPEU_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[src/fpeu_pkg.sv]
// ----------------------------------------------------------------------------
// fpeu_pkg
// types, codes and helper functions shared by the execute unit modules
// ----------------------------------------------------------------------------
package fpeu_pkg;

   typedef enum logic [4:0] {
      OP_ADDI   = 5'd0,
      OP_ADDIS  = 5'd1,
      OP_ADDIC  = 5'd2,
      OP_SUBFIC = 5'd3,
      OP_MULLI  = 5'd4,
      OP_ADD    = 5'd5,
      OP_SUBF   = 5'd6,
      OP_SUBFE  = 5'd7,
      OP_ANDC   = 5'd8,
      OP_OR     = 5'd9,
      OP_ORI    = 5'd10,
      OP_ANDI   = 5'd11,
      OP_RLWINM = 5'd12,
      OP_RLWIMI = 5'd13,
      OP_MULLW  = 5'd14,
      OP_DIVWU  = 5'd15,
      OP_CMPI   = 5'd16,
      OP_CMPLI  = 5'd17,
      OP_CMPL   = 5'd18,
      OP_TWI    = 5'd19
   } fpeu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LATCH,
      ST_EXEC,
      ST_ITER,
      ST_FINISH
   } fpeu_state_type;

   typedef struct packed {
      logic capture;
      logic latch_ab;
      logic exec;
      logic mul_step;
      logic div_step;
      logic commit;
   } fpeu_cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic unit_done;
   } fpeu_sts_type;

   localparam logic [4:0]  MUL_LAST = 5'd3;
   localparam logic [4:0]  DIV_LAST = 5'd31;
   localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
   localparam logic [3:0]  CR_LT    = 4'b1000;
   localparam logic [3:0]  CR_GT    = 4'b0100;
   localparam logic [3:0]  CR_EQ    = 4'b0010;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [3:0] cmp_code(input logic [63:0] x, input logic [63:0] y,
                                           input logic sgn);
      logic [63:0] xs;
      logic [63:0] ys;
      xs = sgn ? (x ^ SIGN64) : x;
      ys = sgn ? (y ^ SIGN64) : y;
      if (xs < ys) return CR_LT;
      else if (xs > ys) return CR_GT;
      else return CR_EQ;
   endfunction

endpackage

[src/fixed_point_execute_unit.sv]
// ----------------------------------------------------------------------------
// fixed_point_execute_unit
// integer execute unit for a 64-bit subset of the power instruction set
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. After an accept, operands come
// from a two-read-port register file with registered reads (ra and rb in
// the same cycle, rs in the next), then execute and commit. mulli and mullw
// add iteration steps for the three 32x32 partial products of the 64-bit
// product; divwu adds steps for the bit-serial divider. The result sits
// in an output register and the next transaction is taken while it
// waits; a result that finds the output register still full holds until
// it is taken.
module fixed_point_execute_unit import fpeu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_operation,
   input  logic [31:0] req_instruction_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [4:0]  rsp_write_index,
   output logic [63:0] rsp_write_value,
   output logic        rsp_carry_out,
   output logic        rsp_cr_updated,
   output logic [2:0]  rsp_cr_field_index,
   output logic [3:0]  rsp_cr_field_value,
   output logic        rsp_trap_taken
);

   fpeu_cmd_type cmd;
   fpeu_sts_type sts;

   fpeu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fpeu_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_operation),
      .req_instruction_word (req_instruction_word),
      .rsp_write_enable     (rsp_write_enable),
      .rsp_write_index      (rsp_write_index),
      .rsp_write_value      (rsp_write_value),
      .rsp_carry_out        (rsp_carry_out),
      .rsp_cr_updated       (rsp_cr_updated),
      .rsp_cr_field_index   (rsp_cr_field_index),
      .rsp_cr_field_value   (rsp_cr_field_value),
      .rsp_trap_taken       (rsp_trap_taken)
   );

endmodule

[src/fpeu_regfile.sv]
// ----------------------------------------------------------------------------
// fpeu_regfile
// 32 x 64 general register file, one write and two registered read ports,
// per-entry valid bits so unwritten registers read as zero after reset
// ----------------------------------------------------------------------------
module fpeu_regfile import fpeu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [63:0] wr_data,
   input  logic [4:0]  rd_addr0,
   input  logic [4:0]  rd_addr1,
   output logic [63:0] rd_data0,
   output logic [63:0] rd_data1
);

   logic [63:0] mem [32];
   logic [31:0] valid_ff;
   logic [63:0] rdata0_ff;
   logic [63:0] rdata1_ff;
   logic        rvalid0_ff;
   logic        rvalid1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata0_ff <= mem[rd_addr0];
      rdata1_ff <= mem[rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rvalid0_ff <= 1'b0;
         rvalid1_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rvalid0_ff <= valid_ff[rd_addr0];
         rvalid1_ff <= valid_ff[rd_addr1];
      end
   end

   assign rd_data0 = rvalid0_ff ? rdata0_ff : '0;
   assign rd_data1 = rvalid1_ff ? rdata1_ff : '0;

endmodule

[src/fpeu_ctrl.sv]
// ----------------------------------------------------------------------------
// fpeu_ctrl
// sequencing state machine: operand read, execute, multiply/divide
// iteration and result commit into the output register
// ----------------------------------------------------------------------------
`include "fixed_point_execute_unit_assert.svh"

module fpeu_ctrl import fpeu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output fpeu_cmd_type cmd,
   input  fpeu_sts_type sts
);

   fpeu_state_type state_ff;
   fpeu_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch_ab = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.is_mul || sts.is_div) ? ST_ITER : ST_FINISH;
         end
         ST_ITER: begin
            cmd.mul_step = sts.is_mul;
            cmd.div_step = sts.is_div;
            if (sts.unit_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FPEU_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, !req_ready, "ready after accept")
   `FPEU_ASSERT_NEXT(a_commit_valid, cmd.commit, rsp_valid_ff, "commit without valid")
   `FPEU_ASSERT_NOW(a_iter_unit, state_ff == ST_ITER, sts.is_mul || sts.is_div, "bad iteration")

endmodule

[src/fpeu_datapath.sv]
// ----------------------------------------------------------------------------
// fpeu_datapath
// operand registers, adder, logic and rotate unit, comparators, four-step
// partial product multiplier, bit-serial divider and output register
// ----------------------------------------------------------------------------
module fpeu_datapath import fpeu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  fpeu_cmd_type cmd,
   output fpeu_sts_type sts,
   input  logic [4:0]   req_operation,
   input  logic [31:0]  req_instruction_word,
   output logic         rsp_write_enable,
   output logic [4:0]   rsp_write_index,
   output logic [63:0]  rsp_write_value,
   output logic         rsp_carry_out,
   output logic         rsp_cr_updated,
   output logic [2:0]   rsp_cr_field_index,
   output logic [3:0]   rsp_cr_field_value,
   output logic         rsp_trap_taken
);

   fpeu_op_type op_ff;
   logic [31:0] word_ff;
   logic [63:0] ra_ff;
   logic [63:0] rb_ff;
   logic        carry_ff;

   logic        we_ff;
   logic [4:0]  wi_ff;
   logic [63:0] wv_ff;
   logic        carry_nx_ff;
   logic        cru_ff;
   logic [2:0]  crf_ff;
   logic [3:0]  crv_ff;
   logic        trap_ff;
   logic        rec_ff;

   logic [4:0]  step_ff;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [31:0] quo_ff;
   logic [31:0] rem_ff;

   logic        o_we_ff;
   logic [4:0]  o_wi_ff;
   logic [63:0] o_wv_ff;
   logic        o_carry_ff;
   logic        o_cru_ff;
   logic [2:0]  o_crf_ff;
   logic [3:0]  o_crv_ff;
   logic        o_trap_ff;

   logic [4:0]  fd;
   logic [4:0]  fa;
   logic [4:0]  fb;
   logic [4:0]  mb;
   logic [4:0]  me;
   logic [2:0]  bf;
   logic        lbit;
   logic        rc;
   logic [15:0] imm;
   logic [63:0] simm;
   logic [63:0] rs;
   logic [63:0] rd0;
   logic [63:0] rd1;

   logic [63:0] add_x;
   logic [63:0] add_y;
   logic        add_c;
   logic [64:0] sum;
   logic [63:0] rot_dbl;
   logic [63:0] rot64;
   logic [63:0] mlo;
   logic [63:0] mhi;
   logic [63:0] mask;
   logic [3:0]  code_s;
   logic [3:0]  code_u;
   logic [63:0] tw_x;

   logic        ex_we;
   logic [4:0]  ex_wi;
   logic [63:0] ex_wv;
   logic        ex_carry;
   logic        ex_cru;
   logic [2:0]  ex_crf;
   logic [3:0]  ex_crv;
   logic        ex_trap;
   logic        ex_rec;

   logic [63:0] mul_a;
   logic [63:0] mul_b;
   logic [31:0] mul_pa;
   logic [31:0] mul_pb;
   logic [63:0] acc_add;
   logic [63:0] acc_sum;
   logic [32:0] rem_sh;
   logic        div_ge;
   logic [31:0] rem_nx;
   logic [31:0] quo_nx;
   logic [3:0]  rec_code;

   assign fd   = word_ff[25:21];
   assign fa   = word_ff[20:16];
   assign fb   = word_ff[15:11];
   assign mb   = word_ff[10:6];
   assign me   = word_ff[5:1];
   assign bf   = word_ff[25:23];
   assign lbit = word_ff[21];
   assign rc   = word_ff[0];
   assign imm  = word_ff[15:0];
   assign simm = sx16(imm);
   assign rs   = rd0;

   fpeu_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd.commit && we_ff),
      .wr_addr  (wi_ff),
      .wr_data  (wv_ff),
      .rd_addr0 (cmd.latch_ab ? fd : fa),
      .rd_addr1 (fb),
      .rd_data0 (rd0),
      .rd_data1 (rd1)
   );

   // shared adder
   always_comb begin
      add_x = ra_ff;
      add_y = rb_ff;
      add_c = 1'b0;
      case (op_ff)
         OP_ADDI:   begin add_x = (fa == 5'd0) ? '0 : ra_ff; add_y = simm; end
         OP_ADDIS:  begin
            add_x = (fa == 5'd0) ? '0 : ra_ff;
            add_y = sx32({imm, 16'h0000});
         end
         OP_ADDIC:  begin add_y = simm; end
         OP_SUBFIC: begin add_x = ~ra_ff; add_y = simm; add_c = 1'b1; end
         OP_SUBF:   begin add_x = ~ra_ff; add_c = 1'b1; end
         OP_SUBFE:  begin add_x = ~ra_ff; add_c = carry_ff; end
         default:   begin end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {64'h0, add_c};

   // rotate and mask
   assign rot_dbl = {rs[31:0], rs[31:0]} << fb;
   assign rot64   = {rot_dbl[63:32], rot_dbl[63:32]};
   assign mlo     = {32'h0, 32'hFFFF_FFFF >> mb};
   assign mhi     = {32'hFFFF_FFFF, 32'hFFFF_FFFF << (5'd31 - me)};
   assign mask    = (mb <= me) ? (mlo & mhi) : (mlo | mhi);

   assign tw_x   = sx32(ra_ff[31:0]);
   assign code_s = cmp_code(tw_x, simm, 1'b1);
   assign code_u = cmp_code(tw_x, simm, 1'b0);

   always_comb begin
      ex_we    = 1'b0;
      ex_wi    = '0;
      ex_wv    = '0;
      ex_carry = carry_ff;
      ex_cru   = 1'b0;
      ex_crf   = '0;
      ex_crv   = '0;
      ex_trap  = 1'b0;
      ex_rec   = 1'b0;
      case (op_ff)
         OP_ADDI, OP_ADDIS, OP_ADD, OP_SUBF: begin
            ex_we  = 1'b1;
            ex_wi  = fd;
            ex_wv  = sum[63:0];
            ex_rec = (op_ff == OP_ADD || op_ff == OP_SUBF) ? rc : 1'b0;
         end
         OP_ADDIC, OP_SUBFIC, OP_SUBFE: begin
            ex_we    = 1'b1;
            ex_wi    = fd;
            ex_wv    = sum[63:0];
            ex_carry = sum[64];
            ex_rec   = (op_ff == OP_SUBFE) ? rc : 1'b0;
         end
         OP_MULLI, OP_MULLW, OP_DIVWU: begin
            ex_we  = 1'b1;
            ex_wi  = fd;
            ex_rec = (op_ff == OP_MULLI) ? 1'b0 : rc;
         end
         OP_ANDC: begin
            ex_we = 1'b1; ex_wi = fa; ex_wv = rs & ~rb_ff; ex_rec = rc;
         end
         OP_OR: begin
            ex_we = 1'b1; ex_wi = fa; ex_wv = rs | rb_ff; ex_rec = rc;
         end
         OP_ORI: begin
            ex_we = 1'b1; ex_wi = fa; ex_wv = rs | {48'h0, imm};
         end
         OP_ANDI: begin
            ex_we = 1'b1; ex_wi = fa; ex_wv = rs & {48'h0, imm}; ex_rec = 1'b1;
         end
         OP_RLWINM: begin
            ex_we = 1'b1; ex_wi = fa; ex_wv = rot64 & mask; ex_rec = rc;
         end
         OP_RLWIMI: begin
            ex_we  = 1'b1;
            ex_wi  = fa;
            ex_wv  = (rot64 & mask) | (ra_ff & ~mask);
            ex_rec = rc;
         end
         OP_CMPI: begin
            ex_cru = 1'b1;
            ex_crf = bf;
            ex_crv = cmp_code(lbit ? ra_ff : tw_x, simm, 1'b1);
         end
         OP_CMPLI: begin
            ex_cru = 1'b1;
            ex_crf = bf;
            ex_crv = cmp_code(lbit ? ra_ff : {32'h0, ra_ff[31:0]}, {48'h0, imm}, 1'b0);
         end
         OP_CMPL: begin
            ex_cru = 1'b1;
            ex_crf = bf;
            ex_crv = cmp_code(lbit ? ra_ff : {32'h0, ra_ff[31:0]},
                              lbit ? rb_ff : {32'h0, rb_ff[31:0]}, 1'b0);
         end
         OP_TWI: begin
            ex_trap = ((code_s == CR_LT) && fd[4]) || ((code_s == CR_GT) && fd[3]) ||
                      ((code_s == CR_EQ) && fd[2]) || ((code_u == CR_LT) && fd[1]) ||
                      ((code_u == CR_GT) && fd[0]);
         end
         default: begin end
      endcase
   end

   // multiplier: low 64 bits from three 32x32 partial products
   assign mul_a = (op_ff == OP_MULLI) ? ra_ff : sx32(ra_ff[31:0]);
   assign mul_b = (op_ff == OP_MULLI) ? simm : sx32(rb_ff[31:0]);

   always_comb begin
      case (step_ff)
         5'd1:    begin mul_pa = mul_a[31:0];  mul_pb = mul_b[63:32]; end
         5'd2:    begin mul_pa = mul_a[63:32]; mul_pb = mul_b[31:0];  end
         default: begin mul_pa = mul_a[31:0];  mul_pb = mul_b[31:0];  end
      endcase
   end

   assign acc_add = (step_ff == 5'd1) ? prod_ff : {prod_ff[31:0], 32'h0};
   assign acc_sum = acc_ff + acc_add;

   // restoring divider, one quotient bit per step
   assign rem_sh = {rem_ff, quo_ff[31]};
   assign div_ge = (rem_sh >= {1'b0, rb_ff[31:0]});
   assign rem_nx = div_ge ? 32'(rem_sh - {1'b0, rb_ff[31:0]}) : rem_sh[31:0];
   assign quo_nx = {quo_ff[30:0], div_ge};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= fpeu_op_type'(req_operation);
         word_ff <= req_instruction_word;
      end
      if (cmd.latch_ab) begin
         ra_ff <= rd0;
         rb_ff <= rd1;
      end
      if (cmd.exec) begin
         we_ff       <= ex_we;
         wi_ff       <= ex_wi;
         wv_ff       <= ex_wv;
         carry_nx_ff <= ex_carry;
         cru_ff      <= ex_cru;
         crf_ff      <= ex_crf;
         crv_ff      <= ex_crv;
         trap_ff     <= ex_trap;
         rec_ff      <= ex_rec;
         step_ff     <= '0;
         quo_ff      <= ra_ff[31:0];
         rem_ff      <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= 64'(mul_pa) * 64'(mul_pb);
         acc_ff  <= (step_ff == 5'd0) ? '0 : acc_sum;
         step_ff <= step_ff + 5'd1;
         if (step_ff == MUL_LAST) begin
            wv_ff <= acc_sum;
         end
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_nx;
         quo_ff  <= quo_nx;
         step_ff <= step_ff + 5'd1;
         if (step_ff == DIV_LAST) begin
            wv_ff <= (rb_ff[31:0] == 32'h0) ? '0 : {32'h0, quo_nx};
         end
      end
      if (cmd.commit) begin
         o_we_ff    <= we_ff;
         o_wi_ff    <= wi_ff;
         o_wv_ff    <= wv_ff;
         o_carry_ff <= carry_nx_ff;
         o_cru_ff   <= cru_ff || rec_ff;
         o_crf_ff   <= rec_ff ? 3'd0 : crf_ff;
         o_crv_ff   <= rec_ff ? rec_code : crv_ff;
         o_trap_ff  <= trap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
      end else if (cmd.commit) begin
         carry_ff <= carry_nx_ff;
      end
   end

   assign rec_code = wv_ff[63] ? CR_LT : ((wv_ff == 64'h0) ? CR_EQ : CR_GT);

   assign sts.is_mul    = (op_ff == OP_MULLI) || (op_ff == OP_MULLW);
   assign sts.is_div    = (op_ff == OP_DIVWU);
   assign sts.unit_done = sts.is_mul ? (step_ff == MUL_LAST) : (step_ff == DIV_LAST);

   assign rsp_write_enable   = o_we_ff;
   assign rsp_write_index    = o_wi_ff;
   assign rsp_write_value    = o_wv_ff;
   assign rsp_carry_out      = o_carry_ff;
   assign rsp_cr_updated     = o_cru_ff;
   assign rsp_cr_field_index = o_crf_ff;
   assign rsp_cr_field_value = o_crv_ff;
   assign rsp_trap_taken     = o_trap_ff;

endmodule
